// ----- sv/lard_pkg.sv -----
// ----------------------------------------------------------------------------
// lard_pkg
// Shared types and constants for the linker address region decoder.
// ----------------------------------------------------------------------------
package lard_pkg;

  localparam int ADDR_W  = 24;
  localparam int CFG_W   = 24;
  localparam int INDEX_W = 3;
  localparam int SPACE_W = 3;

  // Default window bases and physical starts.
  localparam logic [ADDR_W-1:0] TEXT_BASE_DEF         = 24'h000000;
  localparam logic [ADDR_W-1:0] DATA_BASE_DEF         = 24'h800000;
  localparam logic [ADDR_W-1:0] EEPROM_BASE_DEF       = 24'h810000;
  localparam logic [ADDR_W-1:0] FLASH_PHYS_START_DEF  = 24'h000000;
  localparam logic [ADDR_W-1:0] EEPROM_PHYS_START_DEF = 24'h000000;

  // Memory space codes.
  localparam logic [SPACE_W-1:0] SP_UNKNOWN = 3'd0;
  localparam logic [SPACE_W-1:0] SP_FLASH   = 3'd1;
  localparam logic [SPACE_W-1:0] SP_REG     = 3'd2;
  localparam logic [SPACE_W-1:0] SP_IO      = 3'd3;
  localparam logic [SPACE_W-1:0] SP_SRAM    = 3'd4;
  localparam logic [SPACE_W-1:0] SP_EEPROM  = 3'd5;

  // Configuration register indexes.
  localparam logic [INDEX_W-1:0] REG_TEXT_WINDOW_LENGTH   = 3'd0;
  localparam logic [INDEX_W-1:0] REG_FLASH_BYTES          = 3'd1;
  localparam logic [INDEX_W-1:0] REG_EEPROM_WINDOW_LENGTH = 3'd2;
  localparam logic [INDEX_W-1:0] REG_EEPROM_BYTES         = 3'd3;
  localparam logic [INDEX_W-1:0] REG_DATA_WINDOW_LENGTH   = 3'd4;
  localparam logic [INDEX_W-1:0] REG_SRAM_BASE            = 3'd5;
  localparam logic [INDEX_W-1:0] REG_SRAM_BYTES           = 3'd6;

  // Data-window class boundaries.
  localparam logic [ADDR_W-1:0] REG_FILE_END = 24'h000020;
  localparam logic [ADDR_W-1:0] IO_END       = 24'h000060;

  typedef struct packed {
    logic [23:0] text_window_length;
    logic [23:0] flash_bytes;
    logic [16:0] eeprom_window_length;
    logic [16:0] eeprom_bytes;
    logic [16:0] data_window_length;
    logic [15:0] sram_base;
    logic [16:0] sram_bytes;
  } lard_cfg_t;

  typedef struct packed {
    logic [SPACE_W-1:0] space_code;
    logic               found;
    logic [ADDR_W-1:0]  phys_addr;
  } lard_result_t;

endpackage

// ----- sv/lard_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lard_cfg_regs
// Configuration register file with plain write port and reset defaults.
// ----------------------------------------------------------------------------
module lard_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lard_pkg::INDEX_W-1:0] cfg_index,
  input  logic [lard_pkg::CFG_W-1:0]   cfg_data,
  output lard_pkg::lard_cfg_t          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_window_length   <= 24'd131072;
      cfg.flash_bytes          <= 24'd32768;
      cfg.eeprom_window_length <= 17'd65536;
      cfg.eeprom_bytes         <= 17'd1024;
      cfg.data_window_length   <= 17'd65440;
      cfg.sram_base            <= 16'd256;
      cfg.sram_bytes           <= 17'd2048;
    end else if (cfg_we) begin
      case (cfg_index)
        lard_pkg::REG_TEXT_WINDOW_LENGTH:   cfg.text_window_length   <= cfg_data;
        lard_pkg::REG_FLASH_BYTES:          cfg.flash_bytes          <= cfg_data;
        lard_pkg::REG_EEPROM_WINDOW_LENGTH: cfg.eeprom_window_length <= cfg_data[16:0];
        lard_pkg::REG_EEPROM_BYTES:         cfg.eeprom_bytes         <= cfg_data[16:0];
        lard_pkg::REG_DATA_WINDOW_LENGTH:   cfg.data_window_length   <= cfg_data[16:0];
        lard_pkg::REG_SRAM_BASE:            cfg.sram_base            <= cfg_data[15:0];
        lard_pkg::REG_SRAM_BYTES:           cfg.sram_bytes           <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/lard_decode.sv -----
// ----------------------------------------------------------------------------
// lard_decode
// Window compare and offset translation for one registered address.
// ----------------------------------------------------------------------------
module lard_decode #(
  parameter logic [lard_pkg::ADDR_W-1:0] TEXT_BASE         = lard_pkg::TEXT_BASE_DEF,
  parameter logic [lard_pkg::ADDR_W-1:0] DATA_BASE         = lard_pkg::DATA_BASE_DEF,
  parameter logic [lard_pkg::ADDR_W-1:0] EEPROM_BASE       = lard_pkg::EEPROM_BASE_DEF,
  parameter logic [lard_pkg::ADDR_W-1:0] FLASH_PHYS_START  = lard_pkg::FLASH_PHYS_START_DEF,
  parameter logic [lard_pkg::ADDR_W-1:0] EEPROM_PHYS_START = lard_pkg::EEPROM_PHYS_START_DEF
) (
  input  logic [lard_pkg::ADDR_W-1:0] addr,
  input  lard_pkg::lard_cfg_t         cfg,
  output lard_pkg::lard_result_t      result
);

  logic [lard_pkg::ADDR_W-1:0] text_off;
  logic [lard_pkg::ADDR_W-1:0] eep_off;
  logic [lard_pkg::ADDR_W-1:0] data_off;
  logic [lard_pkg::ADDR_W-1:0] sram_off;
  logic [lard_pkg::ADDR_W-1:0] sram_base_ext;
  logic                        text_hit;
  logic                        eep_hit;
  logic                        data_hit;
  logic                        sram_hit;
  logic                        xio_hit;

  assign text_off      = addr - TEXT_BASE;
  assign eep_off       = addr - EEPROM_BASE;
  assign data_off      = addr - DATA_BASE;
  assign sram_base_ext = {8'd0, cfg.sram_base};
  assign sram_off      = data_off - sram_base_ext;

  assign text_hit = (cfg.text_window_length != '0) && (addr >= TEXT_BASE) &&
                    (text_off < cfg.text_window_length);
  assign eep_hit  = (cfg.eeprom_window_length != '0) && (addr >= EEPROM_BASE) &&
                    (eep_off < {7'd0, cfg.eeprom_window_length});
  assign data_hit = (cfg.data_window_length != '0) && (addr >= DATA_BASE) &&
                    (data_off < {7'd0, cfg.data_window_length});
  // Extended I/O exists only when SRAM starts above the plain I/O range.
  assign xio_hit  = (sram_base_ext > lard_pkg::IO_END) && (data_off < sram_base_ext);
  assign sram_hit = (cfg.sram_bytes != '0) && (data_off >= sram_base_ext) &&
                    (sram_off < {7'd0, cfg.sram_bytes});

  always_comb begin
    result.space_code = lard_pkg::SP_UNKNOWN;
    result.phys_addr  = '0;
    if (text_hit) begin
      if (text_off < cfg.flash_bytes) begin
        result.space_code = lard_pkg::SP_FLASH;
        result.phys_addr  = FLASH_PHYS_START + text_off;
      end
    end else if (eep_hit) begin
      if (eep_off < {7'd0, cfg.eeprom_bytes}) begin
        result.space_code = lard_pkg::SP_EEPROM;
        result.phys_addr  = EEPROM_PHYS_START + eep_off;
      end
    end else if (data_hit) begin
      if (data_off < lard_pkg::REG_FILE_END) begin
        result.space_code = lard_pkg::SP_REG;
        result.phys_addr  = data_off;
      end else if (data_off < lard_pkg::IO_END || xio_hit) begin
        result.space_code = lard_pkg::SP_IO;
        result.phys_addr  = data_off;
      end else if (sram_hit) begin
        result.space_code = lard_pkg::SP_SRAM;
        result.phys_addr  = data_off;
      end
    end
    result.found = (result.space_code != lard_pkg::SP_UNKNOWN);
  end

endmodule

// ----- sv/linker_address_region_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// linker_address_region_decoder_unit
// Classifies a linker address into a memory space and physical address.
// ----------------------------------------------------------------------------
// Timing: an accepted start is captured in the input register, and done and
// the result are loaded from the decoder into the result register behind it.
// Throughput: one transaction per cycle; busy is never raised, and the
// input register and the result register form a two-stage pipeline.
// Reset: synchronous rst clears the pipeline valid flags and loads every
// configuration register with its default. The receiver cannot stall, so
// each result is presented for exactly one cycle, marked by done.
module linker_address_region_decoder_unit #(
  parameter logic [lard_pkg::ADDR_W-1:0] TEXT_BASE         = lard_pkg::TEXT_BASE_DEF,
  parameter logic [lard_pkg::ADDR_W-1:0] DATA_BASE         = lard_pkg::DATA_BASE_DEF,
  parameter logic [lard_pkg::ADDR_W-1:0] EEPROM_BASE       = lard_pkg::EEPROM_BASE_DEF,
  parameter logic [lard_pkg::ADDR_W-1:0] FLASH_PHYS_START  = lard_pkg::FLASH_PHYS_START_DEF,
  parameter logic [lard_pkg::ADDR_W-1:0] EEPROM_PHYS_START = lard_pkg::EEPROM_PHYS_START_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // Command channel.
  input  logic                         start,
  output logic                         busy,
  input  logic [lard_pkg::ADDR_W-1:0]  linker_addr,
  // Result channel.
  output logic                         done,
  output logic [lard_pkg::SPACE_W-1:0] space_code,
  output logic                         found,
  output logic [lard_pkg::ADDR_W-1:0]  phys_addr,
  // Configuration write port.
  input  logic                         cfg_we,
  input  logic [lard_pkg::INDEX_W-1:0] cfg_index,
  input  logic [lard_pkg::CFG_W-1:0]   cfg_data
);

  lard_pkg::lard_cfg_t         cfg;
  lard_pkg::lard_result_t      dec_result;
  logic                        addr_valid;
  logic [lard_pkg::ADDR_W-1:0] addr_reg;

  // The decoder has no internal state, so a new transaction is always welcome.
  assign busy = 1'b0;

  lard_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input stage: capture the address of each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_valid <= 1'b0;
    end else begin
      addr_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      addr_reg <= linker_addr;
    end
  end

  lard_decode #(
    .TEXT_BASE         (TEXT_BASE),
    .DATA_BASE         (DATA_BASE),
    .EEPROM_BASE       (EEPROM_BASE),
    .FLASH_PHYS_START  (FLASH_PHYS_START),
    .EEPROM_PHYS_START (EEPROM_PHYS_START)
  ) u_decode (
    .addr   (addr_reg),
    .cfg    (cfg),
    .result (dec_result)
  );

  // Result stage: the strobe is pulsed for one cycle per transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= addr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (addr_valid) begin
      space_code <= dec_result.space_code;
      found      <= dec_result.found;
      phys_addr  <= dec_result.phys_addr;
    end
  end

`ifndef SYNTHESIS
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted transaction did not produce a result");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##2 !done)
    else $error("result strobe without an accepted transaction");

  a_found_matches_space: assert property (@(posedge clk) disable iff (rst)
    done |-> (found == (space_code != lard_pkg::SP_UNKNOWN)))
    else $error("found flag disagrees with space code");

  a_unknown_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (phys_addr == '0))
    else $error("unknown result carries a nonzero address");

  a_space_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (space_code <= lard_pkg::SP_EEPROM))
    else $error("space code outside the defined set");
`endif

endmodule
